@@ design/esm_pkg.sv @@
// ----------------------------------------------------------------------------
// esm_pkg: shared types and constants of the slice/sector map unit
// Holds the result kind codes, the internal word formats and the widths that
// the front, the queue and the divider back end agree on.
// ----------------------------------------------------------------------------
`default_nettype none

package esm_pkg;

  // Sectors at or above 2**SECTOR_W are out of range.
  localparam int SECTOR_W = 32;
  // Width of wide sums (products, slice sums, forward sector results).
  localparam int CALC_W   = 44;
  // Dividend and divisor widths of the pipelined divider.
  localparam int DIV_W    = 41;
  localparam int DVS_W    = 32;

  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;

  localparam logic [MID_AW:0] MID_CNT_FULL = (MID_AW + 1)'(MID_DEPTH);
  localparam logic [OUT_AW:0] OUT_CNT_FULL = (OUT_AW + 1)'(OUT_DEPTH);

  localparam logic [CALC_W-1:0] SECTOR_LIMIT    = CALC_W'(1) << SECTOR_W;
  localparam logic [CALC_W-1:0] MAX_SLICE       = CALC_W'(254);
  localparam logic [4:0]        MIN_PERIOD_LOG2 = 5'd5;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_ECC    = 3'd1,
    KIND_PAD    = 3'd2,
    KIND_HEADER = 3'd3,
    KIND_RANGE  = 3'd4
  } kind_t;

  // What the back end still has to do with a word.
  typedef enum logic [1:0] {
    OP_DONE    = 2'd0,
    OP_FWD_DIV = 2'd1,
    OP_INV_DIV = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_DATA_SLICES        = 2'd0,
    CFG_SECTORS_PER_SLICE  = 2'd1,
    CFG_PROTECTED_COUNT    = 2'd2,
    CFG_HEADER_PERIOD_LOG2 = 2'd3
  } cfg_reg_t;

  // Layout figures derived from the configuration registers.
  typedef struct packed {
    logic [7:0]  data_slices;
    logic [31:0] slice_size;
    logic [31:0] protected_count;
    logic [4:0]  period_log2;
    logic [31:0] period_m2;
    logic [32:0] hdr_start;
    logic [31:0] base;
  } cfgd_t;

  // Word passed from the front to the back end.
  typedef struct packed {
    op_t               op;
    kind_t             kind;
    logic [31:0]       sector;
    logic [31:0]       position;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [CALC_W-1:0] acc;
  } mid_t;

  typedef struct packed {
    logic [31:0] sector;
    logic [7:0]  slice;
    logic [31:0] position;
    kind_t       kind;
  } out_t;

endpackage

`default_nettype wire

@@ design/ecc_slice_sector_map_unit.sv @@
// ----------------------------------------------------------------------------
// ecc_slice_sector_map_unit: slice/position <-> image sector translation
// Top level: configuration registers, front, queue and divider back end.
// ----------------------------------------------------------------------------
// Returns one result word per input word, in order. Command 0 maps (slice,
// position) to an image sector; command 1 maps a sector back to (slice,
// position) or to a header repeat number. The rate is one word per cycle
// unless a full result buffer stalls the divider. Between the accepting edge
// and empty going low lie two front steps, one queue slot, 42 divider stage
// registers (a load stage and 41 stages of one quotient bit each) and the
// result buffer; the divider sets the latency. Write configuration only while
// the unit is drained; the config port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_slice_sector_map_unit
  import esm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_slice_number,
  input  wire logic [31:0] in_position_in_slice,
  input  wire logic [31:0] in_sector_number,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [31:0]      out_sector_out,
  output logic [7:0]       out_slice_out,
  output logic [31:0]      out_position_out,
  output logic [2:0]       out_kind
);

  logic [7:0]  data_slices_r;
  logic [31:0] sectors_per_slice_r;
  logic [31:0] protected_count_r;
  logic [4:0]  header_period_log2_r;

  cfgd_t cfgd;
  logic [31:0] period;
  logic [32:0] round_up;
  logic [32:0] base_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_slices_r        <= 8'd223;
      sectors_per_slice_r  <= 32'd1;
      protected_count_r    <= 32'd3;
      header_period_log2_r <= 5'd5;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DATA_SLICES:        data_slices_r        <= cfg_data[7:0];
        CFG_SECTORS_PER_SLICE:  sectors_per_slice_r  <= cfg_data;
        CFG_PROTECTED_COUNT:    protected_count_r    <= cfg_data;
        CFG_HEADER_PERIOD_LOG2: header_period_log2_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Derive layout figures: zero slice size counts as one, short periods
  // clamp to 32 sectors, first header repeat rounds protected_count up.
  always_comb begin
    cfgd.data_slices     = data_slices_r;
    cfgd.slice_size      = (sectors_per_slice_r == 32'd0) ? 32'd1 : sectors_per_slice_r;
    cfgd.protected_count = protected_count_r;
    cfgd.period_log2     = (header_period_log2_r < MIN_PERIOD_LOG2) ? MIN_PERIOD_LOG2
                                                                     : header_period_log2_r;
    period               = 32'd1 << cfgd.period_log2;
    cfgd.period_m2       = period - 32'd2;
    round_up             = {1'b0, protected_count_r} + {1'b0, period} - 33'd1;
    cfgd.hdr_start       = (round_up >> cfgd.period_log2) << cfgd.period_log2;
    base_full            = cfgd.hdr_start - {1'b0, protected_count_r};
    cfgd.base            = base_full[31:0];
  end

  logic mid_push, mid_full, mid_pop, mid_empty;
  mid_t mid_wdata, mid_rdata;
  out_t out_data;

  esm_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfgd),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_command           (in_command),
    .in_slice_number      (in_slice_number),
    .in_position_in_slice (in_position_in_slice),
    .in_sector_number     (in_sector_number),
    .mid_push             (mid_push),
    .mid_data             (mid_wdata),
    .mid_full             (mid_full)
  );

  esm_midq u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  esm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_rdata (mid_rdata),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  assign out_sector_out   = out_data.sector;
  assign out_slice_out    = out_data.slice;
  assign out_position_out = out_data.position;
  assign out_kind         = out_data.kind;

endmodule

`default_nettype wire

@@ design/esm_midq.sv @@
// ----------------------------------------------------------------------------
// esm_midq: short queue between front and back end
// Four-entry first-in first-out buffer of classified words.
// ----------------------------------------------------------------------------
`default_nettype none

module esm_midq
  import esm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire mid_t wdata,
  output logic      full,
  input  wire logic pop,
  output mid_t      rdata,
  output logic      empty
);

  mid_t              mem_r [MID_DEPTH];
  logic [MID_AW-1:0] wp_r, wp_nxt;
  logic [MID_AW-1:0] rp_r, rp_nxt;
  logic [MID_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == MID_CNT_FULL);
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (MID_AW + 1)'(push) - (MID_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ design/esm_front.sv @@
// ----------------------------------------------------------------------------
// esm_front: accept and classify
// Two steps: form the slice product and sector compares, then finish the
// short cases and prepare dividend, divisor and sum for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module esm_front
  import esm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfgd_t       cfg,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_slice_number,
  input  wire logic [31:0] in_position_in_slice,
  input  wire logic [31:0] in_sector_number,
  output logic             mid_push,
  output mid_t             mid_data,
  input  wire logic        mid_full
);

  typedef struct packed {
    logic        cmd;
    logic        is_data;
    logic [39:0] prod;
    logic [31:0] pos;
    logic [31:0] sector;
    logic        over;
    logic        lt_pc;
    logic        lt_fr;
    logic        hdr_bits;
    logic [31:0] ta;
    logic [32:0] t0;
    logic [31:0] hdr_pos;
  } fa_t;

  fa_t  fa_r, fa_nxt;
  logic v1_r, v1_nxt;
  logic accept;

  logic [7:0]  mul_a;
  logic [32:0] diff;
  logic [32:0] hdr_shift;

  assign in_full  = v1_r && mid_full;
  assign accept   = in_push && !in_full;
  assign mid_push = v1_r && !mid_full;
  assign v1_nxt   = accept || (v1_r && mid_full);

  // First step: product and sector compares.
  always_comb begin
    fa_nxt.cmd      = in_command;
    fa_nxt.is_data  = (in_slice_number < cfg.data_slices);
    mul_a           = fa_nxt.is_data ? in_slice_number : in_slice_number - cfg.data_slices;
    fa_nxt.prod     = 40'(mul_a) * 40'(cfg.slice_size);
    fa_nxt.pos      = in_position_in_slice;
    fa_nxt.sector   = in_sector_number;
    fa_nxt.over     = (CALC_W'(in_sector_number) >= SECTOR_LIMIT);
    fa_nxt.lt_pc    = (in_sector_number < cfg.protected_count);
    fa_nxt.lt_fr    = ({1'b0, in_sector_number} < cfg.hdr_start);
    fa_nxt.hdr_bits = ((in_sector_number & cfg.period_m2) == 32'd0);
    fa_nxt.ta       = in_sector_number - cfg.protected_count;
    diff            = {1'b0, in_sector_number} - cfg.hdr_start;
    fa_nxt.t0       = diff - 33'd2;
    hdr_shift       = diff >> cfg.period_log2;
    fa_nxt.hdr_pos  = hdr_shift[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fa_r <= fa_nxt;
    end
  end

  // Second step: short cases and divider set-up.
  logic [40:0]       idx;
  logic [CALC_W-1:0] res_low;
  logic [CALC_W-1:0] y_sum;
  logic [40:0]       x_val;
  logic [DIV_W-1:0]  t_late;
  logic [32:0]       t0_shift;

  always_comb begin
    idx      = 41'(fa_r.prod) + 41'(fa_r.pos);
    res_low  = CALC_W'(idx) + CALC_W'(cfg.protected_count);
    y_sum    = res_low + CALC_W'(2);
    x_val    = idx - 41'(cfg.base);
    t0_shift = (fa_r.t0 >> cfg.period_log2) << 1;
    t_late   = DIV_W'(fa_r.t0) - DIV_W'(t0_shift) + DIV_W'(cfg.base);

    mid_data          = '0;
    mid_data.op       = OP_DONE;
    mid_data.kind     = KIND_RANGE;
    mid_data.divisor  = cfg.slice_size;

    if (!fa_r.cmd) begin
      if (fa_r.is_data) begin
        if (idx >= 41'(cfg.protected_count)) begin
          mid_data.kind = KIND_PAD;
        end else if (CALC_W'(idx) < SECTOR_LIMIT) begin
          mid_data.kind   = KIND_DATA;
          mid_data.sector = idx[31:0];
        end
      end else if (idx < 41'(cfg.base)) begin
        if (res_low < SECTOR_LIMIT) begin
          mid_data.kind   = KIND_ECC;
          mid_data.sector = res_low[31:0];
        end
      end else begin
        mid_data.op       = OP_FWD_DIV;
        mid_data.kind     = KIND_ECC;
        mid_data.dividend = DIV_W'(x_val);
        mid_data.divisor  = cfg.period_m2;
        mid_data.acc      = y_sum;
      end
    end else if (fa_r.over) begin
      mid_data.kind = KIND_RANGE;
    end else if (fa_r.lt_pc) begin
      mid_data.op       = OP_INV_DIV;
      mid_data.kind     = KIND_DATA;
      mid_data.dividend = DIV_W'(fa_r.sector);
    end else if (!fa_r.lt_fr && fa_r.hdr_bits) begin
      mid_data.kind     = KIND_HEADER;
      mid_data.position = fa_r.hdr_pos;
    end else if (fa_r.lt_fr) begin
      mid_data.op       = OP_INV_DIV;
      mid_data.kind     = KIND_ECC;
      mid_data.dividend = DIV_W'(fa_r.ta);
      mid_data.acc      = CALC_W'(cfg.data_slices);
    end else begin
      mid_data.op       = OP_INV_DIV;
      mid_data.kind     = KIND_ECC;
      mid_data.dividend = t_late;
      mid_data.acc      = CALC_W'(cfg.data_slices);
    end
  end

endmodule

`default_nettype wire

@@ design/esm_back.sv @@
// ----------------------------------------------------------------------------
// esm_back: divider pipeline and result buffer
// Restoring divider, one quotient bit per stage, then the final sum and range
// check into a four-entry result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module esm_back
  import esm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire mid_t         mid_rdata,
  input  wire logic         mid_empty,
  output logic              mid_pop,
  output logic              out_empty,
  input  wire logic         out_pop,
  output out_t              out_data
);

  typedef struct packed {
    mid_t             m;
    logic [DVS_W-1:0] rem;
  } stg_t;

  stg_t stg_r   [DIV_W+1];
  stg_t stg_nxt [DIV_W+1];
  logic vld_r   [DIV_W+1];

  out_t              ofifo_r [OUT_DEPTH];
  logic [OUT_AW-1:0] owp_r, orp_r;
  logic [OUT_AW:0]   ocnt_r;

  logic adv, opop_fire, opush_ok, opush;
  out_t fin;

  function automatic stg_t div_step(stg_t s);
    stg_t          o;
    logic [DVS_W:0] r2;
    logic [DVS_W:0] d2;
    logic [DVS_W:0] dif;
    logic           qb;
    o   = s;
    r2  = {s.rem, s.m.dividend[DIV_W-1]};
    d2  = {1'b0, s.m.divisor};
    dif = r2 - d2;
    qb  = (r2 >= d2);
    o.rem = qb ? dif[DVS_W-1:0] : r2[DVS_W-1:0];
    o.m.dividend = {s.m.dividend[DIV_W-2:0], qb};
    return o;
  endfunction

  assign opop_fire = out_pop && !out_empty;
  assign opush_ok  = (ocnt_r != OUT_CNT_FULL) || opop_fire;
  assign adv       = !vld_r[DIV_W] || opush_ok;
  assign mid_pop   = adv && !mid_empty;
  assign opush     = vld_r[DIV_W] && opush_ok;

  always_comb begin
    stg_nxt[0] = {mid_rdata, {DVS_W{1'b0}}};
    for (int k = 0; k < DIV_W; k++) begin
      stg_nxt[k+1] = div_step(stg_r[k]);
    end
  end

  // Advance all stages together; hold them when a word waits on a full buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_W; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= mid_pop;
      for (int k = 0; k < DIV_W; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= DIV_W; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // Finish: add the quotient in and check the range.
  logic [CALC_W-1:0] q_wide;
  logic [CALC_W-1:0] sum;
  always_comb begin
    q_wide = CALC_W'(stg_r[DIV_W].m.dividend);
    sum    = '0;
    fin    = '0;
    fin.kind = KIND_RANGE;
    case (stg_r[DIV_W].m.op)
      OP_FWD_DIV: begin
        sum = stg_r[DIV_W].m.acc + (q_wide << 1);
        if (sum < SECTOR_LIMIT) begin
          fin.kind   = KIND_ECC;
          fin.sector = sum[31:0];
        end
      end
      OP_INV_DIV: begin
        sum = stg_r[DIV_W].m.acc + q_wide;
        if (sum <= MAX_SLICE) begin
          fin.kind     = stg_r[DIV_W].m.kind;
          fin.slice    = sum[7:0];
          fin.position = stg_r[DIV_W].rem;
        end
      end
      default: begin
        fin.kind     = stg_r[DIV_W].m.kind;
        fin.sector   = stg_r[DIV_W].m.sector;
        fin.position = stg_r[DIV_W].m.position;
      end
    endcase
  end

  assign out_empty = (ocnt_r == '0);
  assign out_data  = ofifo_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (opush) begin
        owp_r <= owp_r + 1'b1;
      end
      if (opop_fire) begin
        orp_r <= orp_r + 1'b1;
      end
      ocnt_r <= ocnt_r + (OUT_AW + 1)'(opush) - (OUT_AW + 1)'(opop_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      ofifo_r[owp_r] <= fin;
    end
  end

`ifndef SYNTH
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OUT_CNT_FULL)
    else $error("result buffer count above depth");
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[DIV_W] && !adv) |=> (vld_r[DIV_W] && $stable(stg_r[DIV_W])))
    else $error("stalled divider output lost");
  a_mid_pop: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

@@ tb/tb_ecc_slice_sector_map_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ecc_slice_sector_map_unit: self-checking bench for the slice/sector map
// Pushes forward and inverse translation words through the unit under a set
// of layout settings, predicts every result word, and checks each popped
// result in order against the prediction, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ecc_slice_sector_map_unit;
  import esm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;  // extra wait once all results are checked

  typedef struct {
    bit        cmd;
    bit [7:0]  slice;
    bit [31:0] pos;
    bit [31:0] sector;
  } map_req_t;

  typedef struct {
    bit [31:0] sector;
    bit [7:0]  slice;
    bit [31:0] pos;
    kind_t     kind;
  } map_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_command = 1'b0;
  logic [7:0]  in_slice_number = '0;
  logic [31:0] in_position_in_slice = '0;
  logic [31:0] in_sector_number = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_sector_out;
  logic [7:0]  out_slice_out;
  logic [31:0] out_position_out;
  logic [2:0]  out_kind;

  ecc_slice_sector_map_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full),
    .in_command(in_command), .in_slice_number(in_slice_number),
    .in_position_in_slice(in_position_in_slice),
    .in_sector_number(in_sector_number),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_sector_out(out_sector_out), .out_slice_out(out_slice_out),
    .out_position_out(out_position_out), .out_kind(out_kind)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the layout registers, kept in step with every cfg write.
  longint unsigned lay_data_slices = 223;
  longint unsigned lay_slice_sectors = 1;
  longint unsigned lay_protected = 3;
  longint unsigned lay_period_log2 = 5;

  map_req_t pending_words[$];
  map_res_t expected_results[$];

  int  error_count = 0;
  int  words_sent = 0;
  int  results_checked = 0;
  int  kind_seen[5];
  int  in_gap = 0;
  int  out_gap = 0;
  bit  calm = 1'b0;
  int  quiet_cycles = 0;

  function automatic longint unsigned header_period();
    longint unsigned lg;
    lg = (lay_period_log2 < 5) ? 5 : lay_period_log2;
    return 64'd1 << lg;
  endfunction

  function automatic longint unsigned first_header();
    longint unsigned p;
    p = header_period();
    return ((lay_protected + p - 1) / p) * p;
  endfunction

  // Work out the translation of one word under the current layout.
  function automatic map_res_t translate_word(map_req_t r);
    map_res_t        o;
    longint unsigned s, p, fr, res, idx, base, x, t, sl, ps;
    o.sector = '0;
    o.slice  = '0;
    o.pos    = '0;
    o.kind   = KIND_DATA;
    s  = (lay_slice_sectors == 0) ? 1 : lay_slice_sectors;
    p  = header_period();
    fr = first_header();
    if (!r.cmd) begin
      if (r.slice < lay_data_slices) begin
        res = r.slice * s + r.pos;
        // data slices past the protected area are padding
        if (res >= lay_protected) begin
          o.kind = KIND_PAD;
          return o;
        end
        o.kind = KIND_DATA;
      end else begin
        idx  = (r.slice - lay_data_slices) * s + r.pos;
        base = fr - lay_protected;
        if (idx < base) begin
          res = lay_protected + idx;
        end else begin
          // skip one header pair per P-2 ecc sectors
          x   = idx - base;
          res = fr + 2 + x + 2 * (x / (p - 2));
        end
        o.kind = KIND_ECC;
      end
      if (res >= (64'd1 << 32)) begin
        o.kind = KIND_RANGE;
        return o;
      end
      o.sector = res[31:0];
      return o;
    end
    if (r.sector < lay_protected) begin
      sl = r.sector / s;
      ps = r.sector % s;
      o.kind = KIND_DATA;
    end else if (r.sector >= fr && (r.sector & (p - 1)) < 2) begin
      // headers only count from the first repeat on
      t = (r.sector - fr) / p;
      o.pos  = t[31:0];
      o.kind = KIND_HEADER;
      return o;
    end else if (r.sector < fr) begin
      t  = r.sector - lay_protected;
      sl = lay_data_slices + t / s;
      ps = t % s;
      o.kind = KIND_ECC;
    end else begin
      t  = r.sector - fr - 2;
      t  = t - 2 * (t / p);
      t  = t + fr - lay_protected;
      sl = lay_data_slices + t / s;
      ps = t % s;
      o.kind = KIND_ECC;
    end
    if (sl > 254) begin
      o.kind = KIND_RANGE;
      return o;
    end
    o.slice = sl[7:0];
    o.pos   = ps[31:0];
    return o;
  endfunction

  // Build a random word aimed at the interesting corners of the layout.
  function automatic map_req_t random_word();
    map_req_t        r;
    longint unsigned v, s, p;
    s = (lay_slice_sectors == 0) ? 1 : lay_slice_sectors;
    p = header_period();
    r.cmd = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 254);
      1: v = lay_data_slices + $urandom_range(0, 4) - 2;
      2: v = $urandom_range(0, 32'((lay_data_slices > 254) ? 254 : lay_data_slices));
      default: v = 254;
    endcase
    if (v > 254) v = 254;
    r.slice = v[7:0];
    case ($urandom_range(0, 3))
      0: r.pos = $urandom_range(0, 15);
      1: r.pos = $urandom_range(0, 32'(s - 1));
      2: r.pos = $urandom;
      default: r.pos = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 40);
      2: v = lay_protected + $urandom_range(0, 8) - 4;
      3: v = first_header() + p * $urandom_range(0, 6) + $urandom_range(0, 3);
      4: v = lay_protected + $urandom_range(0, 32'(s * 40 > 32'hFFFF_FFFF ? 32'hFFFF_FFFF
                                                                       : s * 40));
      default: v = 32'hFFFF_FFFF;
    endcase
    r.sector = v[31:0];
    return r;
  endfunction

  task automatic add_word(bit cmd, bit [7:0] slice, bit [31:0] pos, bit [31:0] sector);
    map_req_t r;
    r.cmd    = cmd;
    r.slice  = slice;
    r.pos    = pos;
    r.sector = sector;
    pending_words.push_back(r);
  endtask

  // Hold the cfg write until the channel takes it, then track the value.
  task automatic write_reg(cfg_reg_t idx, bit [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      CFG_DATA_SLICES:        lay_data_slices   = value[7:0];
      CFG_SECTORS_PER_SLICE:  lay_slice_sectors = value;
      CFG_PROTECTED_COUNT:    lay_protected     = value;
      CFG_HEADER_PERIOD_LOG2: lay_period_log2   = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every word is through and the pipe has emptied.
  task automatic drain();
    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: present the oldest pending word, drop push during gap bursts.
  always @(negedge clk) begin
    if (in_gap > 0) begin
      in_gap <= in_gap - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      in_gap <= $urandom_range(1, 3);
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_gap <= $urandom_range(1, 3);
    end
    in_push <= rst_n && pending_words.size() != 0 && in_gap == 0;
    if (pending_words.size() != 0) begin
      in_command           <= pending_words[0].cmd;
      in_slice_number      <= pending_words[0].slice;
      in_position_in_slice <= pending_words[0].pos;
      in_sector_number     <= pending_words[0].sector;
    end
    out_pop <= rst_n && out_gap == 0;
  end

  // Monitor: predict on accept, check on pop, and watch for a hang.
  always @(posedge clk) begin
    map_res_t exp_res;
    bit       moved;
    moved = cfg_valid && cfg_ready;
    if (rst_n && in_push && !in_full) begin
      expected_results.push_back(translate_word(pending_words[0]));
      void'(pending_words.pop_front());
      words_sent++;
      moved = 1'b1;
    end
    if (rst_n && out_pop && !out_empty) begin
      moved = 1'b1;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with nothing expected, got kind %0d", $time, out_kind);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (exp_res.kind <= KIND_RANGE) kind_seen[exp_res.kind]++;
        if (out_sector_out !== exp_res.sector) begin
          $display("%0t: sector_out expected %h got %h", $time, exp_res.sector, out_sector_out);
          error_count++;
        end
        if (out_slice_out !== exp_res.slice) begin
          $display("%0t: slice_out expected %h got %h", $time, exp_res.slice, out_slice_out);
          error_count++;
        end
        if (out_position_out !== exp_res.pos) begin
          $display("%0t: position_out expected %h got %h", $time, exp_res.pos,
                   out_position_out);
          error_count++;
        end
        if (out_kind !== exp_res.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, exp_res.kind, out_kind);
          error_count++;
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_ecc_slice_sector_map_unit: done, errors");
      $finish;
    end
  end

  // Layout sweep: data slices, slice size, protected count, period log2.
  bit [31:0] sweep[8][4] = '{
    '{32'd1,   32'd0,          32'd3,          32'd0},
    '{32'd254, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd31},
    '{32'd16,  32'd8,          32'd100,        32'd5},
    '{32'd200, 32'd1000,       32'd150000,     32'd10},
    '{32'd3,   32'd7,          32'd20,         32'd3},
    '{32'd128, 32'h0100_0000,  32'h8000_0001,  32'd20},
    '{32'd223, 32'd40,         32'd8920,       32'd6},
    '{32'd100, 32'd3,          32'd301,        32'd5}
  };

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset layout: 223 data slices, one sector per
    // slice, 3 protected sectors, header period 32 first repeating at 32.
    add_word(1'b0, 8'd0,   32'd0,          32'hFFFF_FFFF);  // first data sector
    add_word(1'b0, 8'd2,   32'd0,          32'd0);          // last protected sector
    add_word(1'b0, 8'd3,   32'd0,          32'd0);          // padding
    add_word(1'b0, 8'd222, 32'hFFFF_FFFF,  32'd0);          // padding, huge position
    add_word(1'b0, 8'd223, 32'd0,          32'd0);          // first ecc sector
    add_word(1'b0, 8'd254, 32'd0,          32'd0);          // ecc past first header
    add_word(1'b0, 8'd254, 32'hFFFF_FFFF,  32'd0);          // ecc, far out
    add_word(1'b0, 8'd223, 32'd29,         32'd0);          // lands right after header
    add_word(1'b1, 8'd0,   32'd0,          32'd0);
    add_word(1'b1, 8'd0,   32'd0,          32'd2);
    add_word(1'b1, 8'd0,   32'd0,          32'd3);          // first ecc sector
    add_word(1'b1, 8'd0,   32'd0,          32'd31);
    add_word(1'b1, 8'd0,   32'd0,          32'd32);         // header pair
    add_word(1'b1, 8'd0,   32'd0,          32'd33);
    add_word(1'b1, 8'd0,   32'd0,          32'd34);
    add_word(1'b1, 8'd0,   32'd0,          32'd64);         // second header
    add_word(1'b1, 8'd0,   32'd0,          32'd100);        // slice past 254
    add_word(1'b1, 8'd255, 32'hFFFF_FFFF,  32'hFFFF_FFFF);  // last sector, slice past 254
    drain();

    // Short header period and zero slice size, before the first repeat.
    write_reg(CFG_DATA_SLICES, 32'd4);
    write_reg(CFG_SECTORS_PER_SLICE, 32'd0);
    write_reg(CFG_PROTECTED_COUNT, 32'd33);
    write_reg(CFG_HEADER_PERIOD_LOG2, 32'd2);
    add_word(1'b1, 8'd0, 32'd0, 32'd32);  // multiple of P but before first repeat
    add_word(1'b1, 8'd0, 32'd0, 32'd64);
    add_word(1'b0, 8'd4, 32'd30, 32'd0);
    add_word(1'b0, 8'd3, 32'd0, 32'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_DATA_SLICES, sweep[ph][0]);
      write_reg(CFG_SECTORS_PER_SLICE, sweep[ph][1]);
      write_reg(CFG_PROTECTED_COUNT, sweep[ph][2]);
      write_reg(CFG_HEADER_PERIOD_LOG2, sweep[ph][3]);
      if (ph == 7) calm = 1'b1;  // last stretch runs with no gaps
      for (int n = 0; n < 140; n++) pending_words.push_back(random_word());
      drain();
    end

    $display("covered %0d words over 10 layouts, %0d results checked", words_sent,
             results_checked);
    $display("kinds: data %0d ecc %0d pad %0d header %0d range %0d", kind_seen[0],
             kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (error_count == 0) begin
      $display("tb_ecc_slice_sector_map_unit: done, clean");
    end else begin
      $display("tb_ecc_slice_sector_map_unit: done, errors");
    end
    $finish;
  end

endmodule
